/* rtl/fpst_pkg.sv */
package fpst_pkg;

  // Fixed field widths.
  localparam int IMG_WIDTH    = 14;
  localparam int DIST_WIDTH   = 31;
  localparam int RADIUS_WIDTH = 31;
  localparam int NORM_WIDTH   = 32;
  localparam int NUM_PLANES   = 4;

  // Reset values, in whole or half pixels and in tenths of a metre.
  localparam int FOCAL_RESET_PIX    = 315;
  localparam int CX_RESET_HALF_PIX  = 639;
  localparam int CY_RESET_HALF_PIX  = 479;
  localparam int WIDTH_RESET_PIX    = 640;
  localparam int HEIGHT_RESET_PIX   = 480;
  localparam int NEAR_RESET_TENTHS  = 1;
  localparam int FAR_RESET_TENTHS   = 100;

  typedef enum logic [2:0] {
    CFG_FOCAL_X       = 3'd0,
    CFG_FOCAL_Y       = 3'd1,
    CFG_CENTER_X      = 3'd2,
    CFG_CENTER_Y      = 3'd3,
    CFG_IMAGE_WIDTH   = 3'd4,
    CFG_IMAGE_HEIGHT  = 3'd5,
    CFG_NEAR_DISTANCE = 3'd6,
    CFG_FAR_DISTANCE  = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    CMD_POINT         = 2'd0,
    CMD_POINT_NO_FAR  = 2'd1,
    CMD_SPHERE        = 2'd2,
    CMD_SPHERE_NO_FAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PLANE_LEFT   = 2'd0,
    PLANE_RIGHT  = 2'd1,
    PLANE_TOP    = 2'd2,
    PLANE_BOTTOM = 2'd3
  } plane_t;

endpackage

/* rtl/fpst_cfg_regs.sv */
module fpst_cfg_regs #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int CFG_WIDTH   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  fpst_pkg::cfg_index_t          cfg_index,
  input  logic [CFG_WIDTH-1:0]          cfg_data,
  output logic signed [VALUE_WIDTH-1:0] plane_a [fpst_pkg::NUM_PLANES],
  output logic signed [VALUE_WIDTH-1:0] plane_b [fpst_pkg::NUM_PLANES],
  output logic [fpst_pkg::DIST_WIDTH-1:0] near_distance,
  output logic [fpst_pkg::DIST_WIDTH-1:0] far_distance
);
  import fpst_pkg::*;

  localparam int EXT_W = ((IMG_WIDTH + FRAC_BITS > VALUE_WIDTH) ?
                          (IMG_WIDTH + FRAC_BITS) : VALUE_WIDTH) + 2;

  localparam logic [VALUE_WIDTH-1:0] FOCAL_RST =
    VALUE_WIDTH'(64'(FOCAL_RESET_PIX) << FRAC_BITS);
  localparam logic [VALUE_WIDTH-1:0] CX_RST =
    VALUE_WIDTH'(64'(CX_RESET_HALF_PIX) << (FRAC_BITS - 1));
  localparam logic [VALUE_WIDTH-1:0] CY_RST =
    VALUE_WIDTH'(64'(CY_RESET_HALF_PIX) << (FRAC_BITS - 1));
  localparam logic [DIST_WIDTH-1:0] NEAR_RST =
    DIST_WIDTH'(((64'(NEAR_RESET_TENTHS) << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [DIST_WIDTH-1:0] FAR_RST =
    DIST_WIDTH'(((64'(FAR_RESET_TENTHS) << FRAC_BITS) + 64'd5) / 64'd10);

  logic signed [VALUE_WIDTH-1:0] focal_x, focal_y, center_x, center_y;
  logic [IMG_WIDTH-1:0]          image_width, image_height;
  logic signed [EXT_W-1:0]       w_fix, h_fix;

  // Clamp a wide signed value into the signed value range.
  function automatic logic signed [VALUE_WIDTH-1:0] sat_value(
    input logic signed [EXT_W-1:0] v
  );
    logic fits;
    fits = (v[EXT_W-1:VALUE_WIDTH-1] == {(EXT_W-VALUE_WIDTH+1){v[EXT_W-1]}});
    if (fits) begin
      return v[VALUE_WIDTH-1:0];
    end else if (v[EXT_W-1]) begin
      return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x       <= FOCAL_RST;
      focal_y       <= FOCAL_RST;
      center_x      <= CX_RST;
      center_y      <= CY_RST;
      image_width   <= IMG_WIDTH'(WIDTH_RESET_PIX);
      image_height  <= IMG_WIDTH'(HEIGHT_RESET_PIX);
      near_distance <= NEAR_RST;
      far_distance  <= FAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCAL_X:       focal_x       <= cfg_data[VALUE_WIDTH-1:0];
        CFG_FOCAL_Y:       focal_y       <= cfg_data[VALUE_WIDTH-1:0];
        CFG_CENTER_X:      center_x      <= cfg_data[VALUE_WIDTH-1:0];
        CFG_CENTER_Y:      center_y      <= cfg_data[VALUE_WIDTH-1:0];
        CFG_IMAGE_WIDTH:   image_width   <= cfg_data[IMG_WIDTH-1:0];
        CFG_IMAGE_HEIGHT:  image_height  <= cfg_data[IMG_WIDTH-1:0];
        CFG_NEAR_DISTANCE: near_distance <= cfg_data[DIST_WIDTH-1:0];
        CFG_FAR_DISTANCE:  far_distance  <= cfg_data[DIST_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Image extent in the fixed point format.
  assign w_fix = EXT_W'(image_width) << FRAC_BITS;
  assign h_fix = EXT_W'(image_height) << FRAC_BITS;

  // Inward side normals; the right and bottom ones can leave the range and clamp.
  assign plane_a[PLANE_LEFT]   = focal_x;
  assign plane_b[PLANE_LEFT]   = center_x;
  assign plane_a[PLANE_RIGHT]  = sat_value(-EXT_W'(focal_x));
  assign plane_b[PLANE_RIGHT]  = sat_value(w_fix - EXT_W'(center_x));
  assign plane_a[PLANE_TOP]    = focal_y;
  assign plane_b[PLANE_TOP]    = center_y;
  assign plane_a[PLANE_BOTTOM] = sat_value(-EXT_W'(focal_y));
  assign plane_b[PLANE_BOTTOM] = sat_value(h_fix - EXT_W'(center_y));

endmodule

/* rtl/fpst_norm_unit.sv */
module fpst_norm_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] plane_a [fpst_pkg::NUM_PLANES],
  input  logic signed [VALUE_WIDTH-1:0] plane_b [fpst_pkg::NUM_PLANES],
  output logic [fpst_pkg::NORM_WIDTH-1:0] norms [fpst_pkg::NUM_PLANES],
  output logic                          busy
);
  import fpst_pkg::*;

  localparam int ITER_W = $clog2(VALUE_WIDTH);
  localparam int PIDX_W = $clog2(NUM_PLANES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQ_A = 4'b0010,
    S_SQ_B = 4'b0100,
    S_ROOT = 4'b1000
  } state_t;

  state_t                        state;
  logic [PIDX_W-1:0]             plane_idx;
  logic [ITER_W-1:0]             iter_cnt;
  logic signed [VALUE_WIDTH-1:0] comp_sel;
  logic [VALUE_WIDTH-1:0]        sq_op;
  logic [2*VALUE_WIDTH-1:0]      sq_prod, acc, rad;
  logic [VALUE_WIDTH-1:0]        rem, root, rem_next, root_next;
  logic [VALUE_WIDTH+1:0]        rem_shift, trial;
  logic                          fits;
  logic                          last_iter;

  // One shared squarer: the first component, then the second one.
  assign comp_sel = (state == S_SQ_A) ? plane_a[plane_idx] : plane_b[plane_idx];
  assign sq_op    = comp_sel[VALUE_WIDTH-1] ? VALUE_WIDTH'(-comp_sel) : VALUE_WIDTH'(comp_sel);
  assign sq_prod  = (2*VALUE_WIDTH)'(sq_op) * (2*VALUE_WIDTH)'(sq_op);

  // Restoring square root, one result bit per cycle from the top.
  assign rem_shift = {rem, rad[2*VALUE_WIDTH-1:2*VALUE_WIDTH-2]};
  assign trial     = {root, 2'b01};
  assign fits      = (rem_shift >= trial);
  assign rem_next  = fits ? VALUE_WIDTH'(rem_shift - trial) : VALUE_WIDTH'(rem_shift);
  assign root_next = {root[VALUE_WIDTH-2:0], fits};
  assign last_iter = (iter_cnt == '0);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      state     <= S_SQ_A;
      plane_idx <= '0;
    end else begin
      case (state)
        S_SQ_A: state <= S_SQ_B;
        S_SQ_B: state <= S_ROOT;
        S_ROOT: begin
          if (last_iter) begin
            plane_idx <= plane_idx + 1'b1;
            state     <= (plane_idx == PIDX_W'(NUM_PLANES - 1)) ? S_IDLE : S_SQ_A;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_SQ_A: acc <= sq_prod;
      S_SQ_B: begin
        rad      <= acc + sq_prod;
        rem      <= '0;
        root     <= '0;
        iter_cnt <= ITER_W'(VALUE_WIDTH - 1);
      end
      S_ROOT: begin
        rad      <= rad << 2;
        rem      <= rem_next;
        root     <= root_next;
        iter_cnt <= iter_cnt - 1'b1;
        if (last_iter) begin
          norms[plane_idx] <= NORM_WIDTH'(root_next);
        end
      end
      default: ;
    endcase
  end

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == S_SQ_A) && (plane_idx == '0))
    else $error("norm recompute did not restart at the first plane");

  a_last_plane_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) && last_iter && (plane_idx == PIDX_W'(NUM_PLANES - 1)) && !start
    |=> !busy)
    else $error("norm unit stayed busy after the last plane");

endmodule

/* rtl/fpst_test_pipe.sv */
module fpst_test_pipe #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept_en,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    cmd,
  input  logic signed [VALUE_WIDTH-1:0] pos_x,
  input  logic signed [VALUE_WIDTH-1:0] pos_y,
  input  logic signed [VALUE_WIDTH-1:0] pos_z,
  input  logic [fpst_pkg::RADIUS_WIDTH-1:0] sphere_radius,
  input  logic signed [VALUE_WIDTH-1:0] plane_a [fpst_pkg::NUM_PLANES],
  input  logic signed [VALUE_WIDTH-1:0] plane_b [fpst_pkg::NUM_PLANES],
  input  logic [fpst_pkg::NORM_WIDTH-1:0] norms [fpst_pkg::NUM_PLANES],
  input  logic [fpst_pkg::DIST_WIDTH-1:0] near_distance,
  input  logic [fpst_pkg::DIST_WIDTH-1:0] far_distance,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          inside_res
);
  import fpst_pkg::*;

  localparam int PR_W  = RADIUS_WIDTH + NORM_WIDTH;
  localparam int SUM_W = ((2*VALUE_WIDTH > PR_W) ? 2*VALUE_WIDTH : PR_W) + 2;
  localparam int LIN_W = ((VALUE_WIDTH > DIST_WIDTH) ? VALUE_WIDTH : DIST_WIDTH) + 2;

  logic en0, en1, en2;
  logic v0, v1;

  logic [1:0]                    s0_cmd;
  logic signed [VALUE_WIDTH-1:0] s0_x, s0_y, s0_z;
  logic [RADIUS_WIDTH-1:0]       s0_r;

  logic                          is_sphere, use_far;
  logic [RADIUS_WIDTH-1:0]       r_eff;
  logic signed [LIN_W-1:0]       near_sum, far_sum;

  logic signed [2*VALUE_WIDTH-1:0] pa_next [NUM_PLANES];
  logic signed [2*VALUE_WIDTH-1:0] pb_next [NUM_PLANES];
  logic [PR_W-1:0]                 pr_next [NUM_PLANES];
  logic signed [2*VALUE_WIDTH-1:0] prod_a [NUM_PLANES];
  logic signed [2*VALUE_WIDTH-1:0] prod_b [NUM_PLANES];
  logic [PR_W-1:0]                 prod_r [NUM_PLANES];
  logic                            near_rej, far_rej;

  logic signed [SUM_W-1:0]         plane_sum [NUM_PLANES];
  logic [NUM_PLANES-1:0]           side_rej;

  // A stage moves when the one after it is empty or moving.
  assign en2       = !res_valid || res_ready;
  assign en1       = !v1 || en2;
  assign en0       = !v0 || en1;
  assign req_ready = en0 && accept_en;

  assign is_sphere = (s0_cmd == CMD_SPHERE) || (s0_cmd == CMD_SPHERE_NO_FAR);
  assign use_far   = (s0_cmd == CMD_POINT) || (s0_cmd == CMD_SPHERE);
  assign r_eff     = is_sphere ? s0_r : '0;

  assign near_sum = LIN_W'(s0_z) - LIN_W'(near_distance) + LIN_W'(r_eff);
  assign far_sum  = LIN_W'(far_distance) - LIN_W'(s0_z) + LIN_W'(r_eff);

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_plane
    localparam bit XAXIS = (k == PLANE_LEFT) || (k == PLANE_RIGHT);
    assign pa_next[k] = plane_a[k] * (XAXIS ? s0_x : s0_y);
    assign pb_next[k] = plane_b[k] * s0_z;
    assign pr_next[k] = r_eff * norms[k];
    assign plane_sum[k] = SUM_W'(prod_a[k]) + SUM_W'(prod_b[k]) + SUM_W'(prod_r[k]);
    assign side_rej[k]  = plane_sum[k][SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en0) begin
        v0 <= req_valid && req_ready;
      end
      if (en1) begin
        v1 <= v0;
      end
      if (en2) begin
        res_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s0_cmd <= cmd;
      s0_x   <= pos_x;
      s0_y   <= pos_y;
      s0_z   <= pos_z;
      s0_r   <= sphere_radius;
    end
    if (en1 && v0) begin
      prod_a   <= pa_next;
      prod_b   <= pb_next;
      prod_r   <= pr_next;
      near_rej <= near_sum[LIN_W-1];
      far_rej  <= use_far && far_sum[LIN_W-1];
    end
    if (en2 && v1) begin
      inside_res <= !(|side_rej) && !near_rej && !far_rej;
    end
  end

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(v1))
    else $error("result appeared without an item in the product stage");

endmodule

/* rtl/frustum_point_sphere_test_core.sv */
// Frustum test for points and spheres given in the camera frame.
//
// Requests arrive on the req channel (valid/ready): a command, a Q16.16
// position and, for sphere commands, a radius. Each request yields exactly
// one result on the res channel (valid/ready): inside_res is 1 when the
// point or sphere touches the pinhole frustum (four side planes, near plane
// and, unless the command drops it, the far plane).
//
// The datapath is a three register pipeline: input register, per-plane
// product register and result register. A request passes these three
// registers in order before res_valid rises, and one request is taken every
// cycle while the receiver keeps up. When res_ready is low the pipeline
// fills up and req_ready drops once all three stages hold requests;
// nothing is lost and order is kept.
//
// The side-plane normal lengths come from a shared squarer and a bit-serial
// square root, one plane after another. This pass runs after reset and after
// every register write, and req_ready stays low until it has finished.
// The user writes registers through cfg_we / cfg_index / cfg_data while no
// request is in flight; the block itself does not enforce this.
module frustum_point_sphere_test_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  fpst_pkg::cfg_index_t          cfg_index,
  input  logic [((VALUE_WIDTH > fpst_pkg::DIST_WIDTH) ?
                 VALUE_WIDTH : fpst_pkg::DIST_WIDTH)-1:0] cfg_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    cmd,
  input  logic signed [VALUE_WIDTH-1:0] pos_x,
  input  logic signed [VALUE_WIDTH-1:0] pos_y,
  input  logic signed [VALUE_WIDTH-1:0] pos_z,
  input  logic [fpst_pkg::RADIUS_WIDTH-1:0] sphere_radius,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          inside_res
);
  import fpst_pkg::*;

  localparam int CFG_WIDTH = (VALUE_WIDTH > DIST_WIDTH) ? VALUE_WIDTH : DIST_WIDTH;

  logic signed [VALUE_WIDTH-1:0] plane_a [NUM_PLANES];
  logic signed [VALUE_WIDTH-1:0] plane_b [NUM_PLANES];
  logic [NORM_WIDTH-1:0]         norms [NUM_PLANES];
  logic [DIST_WIDTH-1:0]         near_distance, far_distance;
  logic                          norm_busy;
  logic                          accept_en;

  // Requests wait while the normal lengths are stale or being written.
  assign accept_en = !rst && !norm_busy && !cfg_we;

  fpst_cfg_regs #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .CFG_WIDTH   (CFG_WIDTH)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .plane_a       (plane_a),
    .plane_b       (plane_b),
    .near_distance (near_distance),
    .far_distance  (far_distance)
  );

  fpst_norm_unit #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_norm (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_we),
    .plane_a (plane_a),
    .plane_b (plane_b),
    .norms   (norms),
    .busy    (norm_busy)
  );

  fpst_test_pipe #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_pipe (
    .clk           (clk),
    .rst           (rst),
    .accept_en     (accept_en),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .cmd           (cmd),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .sphere_radius (sphere_radius),
    .plane_a       (plane_a),
    .plane_b       (plane_b),
    .norms         (norms),
    .near_distance (near_distance),
    .far_distance  (far_distance),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .inside_res    (inside_res)
  );

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    norm_busy |-> !req_ready)
    else $error("request taken while normal lengths were being recomputed");

  a_write_starts_update: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> norm_busy)
    else $error("register write did not start a normal length update");

endmodule
